FILE: rtl/core/y4m_pkg.sv
// Shared types and constants for the Y4M luma extractor.
// Holds the parser phase codes, result codes, character codes and the result struct.
// No dependencies.
`default_nettype none

package y4m_pkg;

    // Parser phase codes.
    localparam logic [3:0] PH_MAGIC      = 4'd0;
    localparam logic [3:0] PH_TOKSTART   = 4'd1;
    localparam logic [3:0] PH_NUMBER     = 4'd2;
    localparam logic [3:0] PH_SKIPTOK    = 4'd3;
    localparam logic [3:0] PH_FRAMEMAGIC = 4'd4;
    localparam logic [3:0] PH_FRAMEPARAM = 4'd5;
    localparam logic [3:0] PH_LUMA       = 4'd6;
    localparam logic [3:0] PH_CHROMA     = 4'd7;
    localparam logic [3:0] PH_DEAD       = 4'd8;

    // Result kinds.
    localparam logic [1:0] KIND_PIXEL  = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // Error codes.
    localparam logic [1:0] ERR_MAGIC = 2'd0;
    localparam logic [1:0] ERR_DIM   = 2'd1;
    localparam logic [1:0] ERR_FRAME = 2'd2;

    // Token kinds.
    localparam logic [1:0] TOK_OTHER  = 2'd0;
    localparam logic [1:0] TOK_WIDTH  = 2'd1;
    localparam logic [1:0] TOK_HEIGHT = 2'd2;

    // Character codes.
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_W       = 8'h57;
    localparam logic [7:0] CH_H       = 8'h48;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    // Lengths of the stream and frame magic strings.
    localparam logic [3:0] MAGIC_LEN = 4'd9;
    localparam logic [3:0] FRAME_LEN = 4'd5;

    // One result transaction, without its valid flag.
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  luma;
        logic        last;
        logic [15:0] width;
        logic [15:0] height;
        logic [1:0]  err;
    } t_result;

    // Character of the stream magic "YUV4MPEG2" at a position.
    function automatic logic [7:0] magic_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = 8'h59; // Y
            4'd1:    c = 8'h55; // U
            4'd2:    c = 8'h56; // V
            4'd3:    c = 8'h34; // 4
            4'd4:    c = 8'h4D; // M
            4'd5:    c = 8'h50; // P
            4'd6:    c = 8'h45; // E
            4'd7:    c = 8'h47; // G
            4'd8:    c = 8'h32; // 2
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Character of the frame marker "FRAME" at a position.
    function automatic logic [7:0] frame_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = 8'h46; // F
            4'd1:    c = 8'h52; // R
            4'd2:    c = 8'h41; // A
            4'd3:    c = 8'h4D; // M
            4'd4:    c = 8'h45; // E
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/y4m_parser.sv
// Byte-level parser state machine of the Y4M luma extractor.
// Depends on y4m_pkg for phase codes, character codes and the result struct.
`default_nettype none

module y4m_parser
    import y4m_pkg::*;
#(
    parameter int DIM_BITS = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_byte,
    output logic            o_res_valid,
    output t_result         o_res
);

    localparam int CNT_BITS = 2 * DIM_BITS;
    localparam int ACC_BITS = DIM_BITS + 4;
    localparam logic [DIM_BITS-1:0] MAXV = '1;

    logic [3:0]          r_phase,  n_phase;
    logic [3:0]          r_match,  n_match;
    logic [1:0]          r_tok,    n_tok;
    logic [DIM_BITS-1:0] r_acc,    n_acc;
    logic [DIM_BITS-1:0] r_width,  n_width;
    logic [DIM_BITS-1:0] r_height, n_height;
    logic [CNT_BITS-1:0] r_size;
    logic [CNT_BITS-1:0] r_cnt,    n_cnt;

    logic [ACC_BITS-1:0] acc_ext;
    logic [ACC_BITS-1:0] acc_next;
    logic [CNT_BITS-1:0] cnt_inc;
    logic [CNT_BITS-1:0] chroma_size;
    logic                is_digit;
    logic                do_end;
    logic                do_err;
    logic [1:0]          err_code;

    // Decimal accumulate: acc * 10 + digit, built from two shifts.
    assign acc_ext     = {4'b0000, r_acc};
    assign acc_next    = (acc_ext << 3) + (acc_ext << 1) + {{(ACC_BITS-4){1'b0}}, i_byte[3:0]};
    assign is_digit    = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign cnt_inc     = r_cnt + 1'b1;
    assign chroma_size = r_size >> 1;

    // Next-state and result logic for one byte.
    always_comb begin
        n_phase     = r_phase;
        n_match     = r_match;
        n_tok       = r_tok;
        n_acc       = r_acc;
        n_width     = r_width;
        n_height    = r_height;
        n_cnt       = r_cnt;
        do_end      = 1'b0;
        do_err      = 1'b0;
        err_code    = ERR_MAGIC;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_step) begin
            unique case (r_phase)
                PH_MAGIC: begin
                    if (r_match < MAGIC_LEN) begin
                        if (i_byte != magic_char(r_match)) begin
                            do_err = 1'b1;
                        end else begin
                            n_match = r_match + 1'b1;
                        end
                    end else if (i_byte == CH_SPACE) begin
                        n_phase = PH_TOKSTART;
                    end else if (i_byte == CH_NEWLINE) begin
                        do_end = 1'b1;
                    end else begin
                        do_err = 1'b1;
                    end
                end
                PH_TOKSTART: begin
                    if (i_byte == CH_NEWLINE) begin
                        do_end = 1'b1;
                    end else if (i_byte == CH_W || i_byte == CH_H) begin
                        n_tok   = (i_byte == CH_W) ? TOK_WIDTH : TOK_HEIGHT;
                        n_acc   = '0;
                        n_phase = PH_NUMBER;
                    end else if (i_byte != CH_SPACE) begin
                        n_tok   = TOK_OTHER;
                        n_phase = PH_SKIPTOK;
                    end
                end
                PH_NUMBER: begin
                    if (is_digit) begin
                        n_acc = (acc_next > {4'b0000, MAXV}) ? MAXV
                                                             : acc_next[DIM_BITS-1:0];
                    end else begin
                        // The number ends here; keep it for its dimension.
                        if (r_tok == TOK_WIDTH) begin
                            n_width = r_acc;
                        end else if (r_tok == TOK_HEIGHT) begin
                            n_height = r_acc;
                        end
                        n_tok = TOK_OTHER;
                        if (i_byte == CH_SPACE) begin
                            n_phase = PH_TOKSTART;
                        end else if (i_byte == CH_NEWLINE) begin
                            do_end = 1'b1;
                        end else begin
                            n_phase = PH_SKIPTOK;
                        end
                    end
                end
                PH_SKIPTOK: begin
                    if (i_byte == CH_SPACE) begin
                        n_phase = PH_TOKSTART;
                    end else if (i_byte == CH_NEWLINE) begin
                        do_end = 1'b1;
                    end
                end
                PH_FRAMEMAGIC: begin
                    err_code = ERR_FRAME;
                    if (r_match < FRAME_LEN) begin
                        if (i_byte != frame_char(r_match)) begin
                            do_err = 1'b1;
                        end else begin
                            n_match = r_match + 1'b1;
                        end
                    end else begin
                        n_match = '0;
                        n_cnt   = '0;
                        if (i_byte == CH_NEWLINE) begin
                            n_phase = PH_LUMA;
                        end else if (i_byte == CH_SPACE) begin
                            n_phase = PH_FRAMEPARAM;
                        end else begin
                            do_err = 1'b1;
                        end
                    end
                end
                PH_FRAMEPARAM: begin
                    if (i_byte == CH_NEWLINE) begin
                        n_cnt   = '0;
                        n_phase = PH_LUMA;
                    end
                end
                PH_LUMA: begin
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_PIXEL;
                    o_res.luma  = i_byte;
                    if (cnt_inc == r_size) begin
                        o_res.last = 1'b1;
                        n_cnt      = '0;
                        n_match    = '0;
                        n_phase    = (chroma_size == '0) ? PH_FRAMEMAGIC : PH_CHROMA;
                    end else begin
                        n_cnt = cnt_inc;
                    end
                end
                PH_CHROMA: begin
                    if (cnt_inc == chroma_size) begin
                        n_cnt   = '0;
                        n_match = '0;
                        n_phase = PH_FRAMEMAGIC;
                    end else begin
                        n_cnt = cnt_inc;
                    end
                end
                PH_DEAD: begin
                    n_phase = PH_DEAD;
                end
                default: begin
                    n_phase = PH_DEAD;
                end
            endcase

            // End of the header line: check the dimensions and report them.
            if (do_end) begin
                if (n_width == '0 || n_height == '0 || n_width == MAXV || n_height == MAXV) begin
                    do_err   = 1'b1;
                    err_code = ERR_DIM;
                end else begin
                    n_match      = '0;
                    n_cnt        = '0;
                    n_phase      = PH_FRAMEMAGIC;
                    o_res_valid  = 1'b1;
                    o_res.kind   = KIND_HEADER;
                    o_res.width  = 16'(n_width);
                    o_res.height = 16'(n_height);
                end
            end

            // Any error is reported once, then the parser goes dead.
            if (do_err) begin
                n_phase     = PH_DEAD;
                o_res_valid = 1'b1;
                o_res       = '0;
                o_res.kind  = KIND_ERROR;
                o_res.err   = err_code;
            end
        end
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_MAGIC;
            r_match  <= '0;
            r_tok    <= TOK_OTHER;
            r_acc    <= '0;
            r_width  <= '0;
            r_height <= '0;
            r_cnt    <= '0;
        end else begin
            r_phase  <= n_phase;
            r_match  <= n_match;
            r_tok    <= n_tok;
            r_acc    <= n_acc;
            r_width  <= n_width;
            r_height <= n_height;
            r_cnt    <= n_cnt;
        end
    end

    // Frame size is formed while waiting for the frame marker; the dimensions
    // are fixed by then and the marker takes at least six bytes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= '0;
        end else if (r_phase == PH_FRAMEMAGIC) begin
            r_size <= CNT_BITS'(r_width) * CNT_BITS'(r_height);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/y4m_luma_extractor.sv
// Top level of the Y4M luma extractor: input register, parser, result register.
// Depends on y4m_pkg and y4m_parser.
//
// Usage: raw Y4M stream bytes enter on the input channel (i_in_valid,
// o_in_ready, i_byte_in), one byte per transaction. Results leave on the
// output channel (o_out_valid, i_out_ready) as luma pixels with a
// last-of-frame flag, a header-done transaction carrying width and height,
// or a single error transaction after which all further bytes are dropped.
// Bytes that produce no result (magic, header tokens, frame markers,
// chroma) are consumed silently.
// An accepted byte is held in the input register; the parser result for it
// is loaded into the result register when that register is empty or being
// drained, and the result then appears on the output.
// Throughput: one byte per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its transaction and
// the input register holds one more byte; then o_in_ready drops.
// Reset (synchronous, active low) clears the valid flags of both registers
// and returns the parser to matching the stream magic; the frame-size
// product is formed while the frame marker is being matched.
`default_nettype none

module y4m_luma_extractor
    import y4m_pkg::*;
#(
    parameter int DIM_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_byte_in,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_out_kind,
    output logic [7:0]       o_luma,
    output logic             o_last_of_frame,
    output logic [15:0]      o_image_width,
    output logic [15:0]      o_image_height,
    output logic [1:0]       o_error_code
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;

    logic       out_free;
    logic       step;
    logic       res_valid;
    t_result    res;

    // The result register can load when empty or being drained.
    assign out_free   = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    y4m_parser #(
        .DIM_BITS (DIM_BITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_byte_in;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_kind      = r_out.kind;
    assign o_luma          = r_out.luma;
    assign o_last_of_frame = r_out.last;
    assign o_image_width   = r_out.width;
    assign o_image_height  = r_out.height;
    assign o_error_code    = r_out.err;

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for y4m_luma_extractor: feeds a Y4M byte stream and checks
// every result transaction against a cycle-free predictor of the parser.
// Depends on y4m_pkg and y4m_luma_extractor.

module tb_top;
    import y4m_pkg::*;

    localparam int DIM_BITS = 16;
    localparam logic [15:0] DIM_MAX = 16'((1 << DIM_BITS) - 1);
    localparam logic [71:0] MAGIC_TAG = "YUV4MPEG2";
    localparam logic [39:0] FRAME_TAG = "FRAME";

    localparam int ITEM_TARGET = 1250;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_CAP = 60;

    // Stream layouts: a clean header, a broken magic, or bad dimensions.
    localparam int SCN_CLEAN = 0;
    localparam int SCN_BAD_MAGIC = 1;
    localparam int SCN_BAD_DIM = 2;

    // One row of the header table: the byte and, where obvious, its result.
    typedef struct packed {
        logic [7:0] ch;
        logic       typed;
        t_result    want;
    } t_header_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [7:0]  i_byte_in = 8'h00;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [1:0]  o_out_kind;
    logic [7:0]  o_luma;
    logic        o_last_of_frame;
    logic [15:0] o_image_width;
    logic [15:0] o_image_height;
    logic [1:0]  o_error_code;

    // Parser state tracked by the predictor.
    logic [3:0]  cur_phase = PH_MAGIC;
    logic [3:0]  tag_pos = 4'd0;
    logic [1:0]  tok_sel = TOK_OTHER;
    logic [15:0] digits_val = 16'd0;
    logic [15:0] hdr_width = 16'd0;
    logic [15:0] hdr_height = 16'd0;
    logic [31:0] plane_size = 32'd0;
    logic [31:0] plane_pos = 32'd0;

    t_result     stream_results_q[$];
    t_header_row header_table[$];
    int          fault_count = 0;
    int          items_sent = 0;
    int          idle_cycles = 0;
    int unsigned cyc = 0;
    bit          steady = 1'b0;
    int          sink_hold = 0;

    y4m_luma_extractor #(
        .DIM_BITS(DIM_BITS)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_byte_in(i_byte_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_kind(o_out_kind),
        .o_luma(o_luma),
        .o_last_of_frame(o_last_of_frame),
        .o_image_width(o_image_width),
        .o_image_height(o_image_height),
        .o_error_code(o_error_code)
    );

    // Clock with a 20 ns period.
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Gap length: mostly none, some short, a few long; none at all in steady stretches.
    function automatic int pick_gap();
        int r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return 0;
        end
        if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // An error result; the parser stays dead afterwards.
    function automatic bit raise_error(input logic [1:0] code, output t_result r);
        r = '0;
        r.kind = KIND_ERROR;
        r.err = code;
        cur_phase = PH_DEAD;
        return 1'b1;
    endfunction

    // End of the header line: report the dimensions or reject them.
    function automatic bit close_header(output t_result r);
        r = '0;
        if (hdr_width == 16'd0 || hdr_height == 16'd0 ||
            hdr_width >= DIM_MAX || hdr_height >= DIM_MAX) begin
            return raise_error(ERR_DIM, r);
        end
        plane_size = 32'(hdr_width) * 32'(hdr_height);
        tag_pos = 4'd0;
        plane_pos = 32'd0;
        cur_phase = PH_FRAMEMAGIC;
        r.kind = KIND_HEADER;
        r.width = hdr_width;
        r.height = hdr_height;
        return 1'b1;
    endfunction

    // Advances the parser by one byte; returns 1 when the byte yields a result.
    function automatic bit parse_stream_byte(input logic [7:0] b, output t_result r);
        logic [31:0] next_val;
        bit hit;
        r = '0;
        hit = 1'b0;
        case (cur_phase)
            PH_MAGIC: begin
                if (tag_pos < MAGIC_LEN) begin
                    if (b != MAGIC_TAG[8 * (8 - int'(tag_pos)) +: 8]) begin
                        hit = raise_error(ERR_MAGIC, r);
                    end else begin
                        tag_pos = tag_pos + 4'd1;
                    end
                end else if (b == CH_SPACE) begin
                    cur_phase = PH_TOKSTART;
                end else if (b == CH_NEWLINE) begin
                    hit = close_header(r);
                end else begin
                    hit = raise_error(ERR_MAGIC, r);
                end
            end
            PH_TOKSTART: begin
                if (b == CH_NEWLINE) begin
                    hit = close_header(r);
                end else if (b == CH_W || b == CH_H) begin
                    tok_sel = (b == CH_W) ? TOK_WIDTH : TOK_HEIGHT;
                    digits_val = 16'd0;
                    cur_phase = PH_NUMBER;
                end else if (b != CH_SPACE) begin
                    tok_sel = TOK_OTHER;
                    cur_phase = PH_SKIPTOK;
                end
            end
            PH_NUMBER: begin
                if (b >= CH_ZERO && b <= CH_NINE) begin
                    // Decimal digits accumulate and saturate at the largest dimension.
                    next_val = 32'(digits_val) * 32'd10 + 32'(b - CH_ZERO);
                    digits_val = (next_val > 32'(DIM_MAX)) ? DIM_MAX : next_val[15:0];
                end else begin
                    if (tok_sel == TOK_WIDTH) begin
                        hdr_width = digits_val;
                    end else if (tok_sel == TOK_HEIGHT) begin
                        hdr_height = digits_val;
                    end
                    tok_sel = TOK_OTHER;
                    if (b == CH_SPACE) begin
                        cur_phase = PH_TOKSTART;
                    end else if (b == CH_NEWLINE) begin
                        hit = close_header(r);
                    end else begin
                        cur_phase = PH_SKIPTOK;
                    end
                end
            end
            PH_SKIPTOK: begin
                if (b == CH_SPACE) begin
                    cur_phase = PH_TOKSTART;
                end else if (b == CH_NEWLINE) begin
                    hit = close_header(r);
                end
            end
            PH_FRAMEMAGIC: begin
                if (tag_pos < FRAME_LEN) begin
                    if (b != FRAME_TAG[8 * (4 - int'(tag_pos)) +: 8]) begin
                        hit = raise_error(ERR_FRAME, r);
                    end else begin
                        tag_pos = tag_pos + 4'd1;
                    end
                end else begin
                    tag_pos = 4'd0;
                    plane_pos = 32'd0;
                    if (b == CH_NEWLINE) begin
                        cur_phase = PH_LUMA;
                    end else if (b == CH_SPACE) begin
                        cur_phase = PH_FRAMEPARAM;
                    end else begin
                        hit = raise_error(ERR_FRAME, r);
                    end
                end
            end
            PH_FRAMEPARAM: begin
                if (b == CH_NEWLINE) begin
                    plane_pos = 32'd0;
                    cur_phase = PH_LUMA;
                end
            end
            PH_LUMA: begin
                r.kind = KIND_PIXEL;
                r.luma = b;
                hit = 1'b1;
                plane_pos = plane_pos + 32'd1;
                if (plane_pos >= plane_size) begin
                    r.last = 1'b1;
                    plane_pos = 32'd0;
                    tag_pos = 4'd0;
                    cur_phase = ((plane_size >> 1) == 32'd0) ? PH_FRAMEMAGIC : PH_CHROMA;
                end
            end
            PH_CHROMA: begin
                // Chroma bytes are counted and dropped.
                plane_pos = plane_pos + 32'd1;
                if (plane_pos >= (plane_size >> 1)) begin
                    plane_pos = 32'd0;
                    tag_pos = 4'd0;
                    cur_phase = PH_FRAMEMAGIC;
                end
            end
            default: begin
                cur_phase = PH_DEAD;
            end
        endcase
        return hit;
    endfunction

    // Appends one predicted result to the end of the pending list.
    task automatic queue_result(input t_result r);
        stream_results_q = {stream_results_q, r};
    endtask

    // Offers one byte after an optional gap and returns once the transaction is accepted.
    task automatic push_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_byte_in <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    // Sends one byte and queues whatever result the parser predicts for it.
    task automatic send_stream_byte(input logic [7:0] b);
        t_result r;
        push_byte(b);
        if (parse_stream_byte(b, r)) begin
            queue_result(r);
        end
    endtask

    // Random byte that is not the one given, nor a separator when asked.
    function automatic logic [7:0] wrong_byte(input logic [7:0] avoid, input bit no_sep);
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (c == avoid || (no_sep && (c == CH_SPACE || c == CH_NEWLINE)));
        return c;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            if (fault_count < REPORT_CAP) begin
                $error("%s expected %0d, got %0d", name, want, got);
            end
            fault_count++;
        end
    endtask

    // Each output transaction is compared with the oldest predicted result.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (stream_results_q.size() == 0) begin
                if (fault_count < REPORT_CAP) begin
                    $error("out_kind %0d arrived with no result pending", o_out_kind);
                end
                fault_count++;
            end else begin
                want = stream_results_q.pop_front();
                check_field("out_kind", 32'(want.kind), 32'(o_out_kind));
                check_field("luma", 32'(want.luma), 32'(o_luma));
                check_field("last_of_frame", 32'(want.last), 32'(o_last_of_frame));
                check_field("image_width", 32'(want.width), 32'(o_image_width));
                check_field("image_height", 32'(want.height), 32'(o_image_height));
                check_field("error_code", 32'(want.err), 32'(o_error_code));
            end
        end
    end

    // Receiver pacing: random stalls on the result channel.
    always @(posedge i_clk) begin : sink_pacing
        int g;
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            i_out_ready <= 1'b0;
        end else begin
            g = pick_gap();
            if (g > 0) begin
                sink_hold <= g - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Whenever the low byte of the cycle counter is zero, decide whether the next stretch runs without any idling.
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc[7:0] == 8'd0) begin
            steady <= ($urandom_range(0, 2) == 0);
        end
    end

    // Watchdog: ends the run when no transaction moves for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[y4m_luma_extractor] ERROR");
            $finish;
        end
    end

    // Stimulus: header table; for a clean header, random frames and a broken marker; then dead bytes.
    initial begin
        int scenario;
        int flaw_pos;
        int dim_flaw;
        int wv;
        int hv;
        int sel;
        int luma_n;
        int param_n;
        int k;
        bit put_w;
        bit put_h;
        logic [7:0] flaw_ch;
        logic [7:0] px;
        string hdr;
        string wtok;
        string htok;
        string tail;
        t_header_row row;
        t_result r;

        sel = $urandom_range(0, 11);
        scenario = (sel == 0) ? SCN_BAD_MAGIC : (sel == 1) ? SCN_BAD_DIM : SCN_CLEAN;

        // Dimensions: mostly small planes, sometimes 1x1, a tall strip or a wide line.
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            wv = 1;
            hv = 1;
        end else if (sel == 1) begin
            wv = $urandom_range(820, 900);
            hv = 1;
        end else if (sel == 2) begin
            wv = 1;
            hv = $urandom_range(2, 9);
        end else begin
            wv = $urandom_range(1, 40);
            hv = $urandom_range(1, 6);
        end
        put_w = 1'b1;
        put_h = 1'b1;
        dim_flaw = $urandom_range(0, 6);
        if (scenario == SCN_BAD_DIM) begin
            case (dim_flaw)
                0: wv = 0;
                1: hv = 0;
                2: wv = int'(DIM_MAX);
                3: hv = 70000;
                4: put_w = 1'b0;
                5: put_h = 1'b0;
                default: wv = 1;
            endcase
        end

        // The header carries a saturating width, an empty height and an unknown
        // token, all overridden or skipped before the real dimensions.
        wtok = put_w ? $sformatf("W%0d ", wv) : "";
        htok = put_h ? $sformatf("H%0d", hv) : "";
        sel = $urandom_range(0, 2);
        tail = (sel == 0) ? "\n" : (sel == 1) ? " \n" : "x\n";
        hdr = $sformatf("YUV4MPEG2  W99999x H Ip %s%s%s", wtok, htok, tail);
        if (scenario == SCN_BAD_DIM && dim_flaw == 6) begin
            hdr = "YUV4MPEG2\n";
        end
        flaw_pos = $urandom_range(0, 9);
        flaw_ch = wrong_byte(hdr[flaw_pos], flaw_pos == 9);

        for (int i = 0; i < hdr.len(); i++) begin
            row = '0;
            row.ch = hdr[i];
            if (scenario == SCN_BAD_MAGIC && i == flaw_pos) begin
                row.ch = flaw_ch;
                row.typed = 1'b1;
                row.want.kind = KIND_ERROR;
                row.want.err = ERR_MAGIC;
            end else if (scenario != SCN_BAD_MAGIC && i == hdr.len() - 1) begin
                row.typed = 1'b1;
                if (scenario == SCN_BAD_DIM) begin
                    row.want.kind = KIND_ERROR;
                    row.want.err = ERR_DIM;
                end else begin
                    row.want.kind = KIND_HEADER;
                    row.want.width = wv[15:0];
                    row.want.height = hv[15:0];
                end
            end
            header_table = {header_table, row};
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: walk the header table.
        foreach (header_table[i]) begin
            push_byte(header_table[i].ch);
            if (parse_stream_byte(header_table[i].ch, r) && !header_table[i].typed) begin
                queue_result(r);
            end
            if (header_table[i].typed) begin
                queue_result(header_table[i].want);
            end
        end

        if (scenario == SCN_CLEAN) begin
            luma_n = wv * hv;
            // Random frames: marker, optional parameters, luma plane, chroma planes.
            while (items_sent < ITEM_TARGET) begin
                for (int j = 0; j < FRAME_LEN; j++) begin
                    send_stream_byte(FRAME_TAG[8 * (4 - j) +: 8]);
                end
                if ($urandom_range(0, 2) == 0) begin
                    send_stream_byte(CH_SPACE);
                    param_n = $urandom_range(0, 8);
                    repeat (param_n) send_stream_byte(wrong_byte(CH_NEWLINE, 1'b0));
                end
                send_stream_byte(CH_NEWLINE);
                repeat (luma_n) begin
                    sel = $urandom_range(0, 15);
                    px = (sel == 0) ? 8'h00 : (sel == 1) ? 8'hFF : 8'($urandom_range(0, 255));
                    send_stream_byte(px);
                end
                repeat (luma_n / 2) send_stream_byte(8'($urandom_range(0, 255)));
            end

            // Broken frame marker: a wrong letter, or a wrong byte after the marker.
            k = $urandom_range(0, 5);
            for (int j = 0; j < k; j++) begin
                send_stream_byte(FRAME_TAG[8 * (4 - j) +: 8]);
            end
            if (k < 5) begin
                send_stream_byte(wrong_byte(FRAME_TAG[8 * (4 - k) +: 8], 1'b0));
            end else begin
                send_stream_byte(wrong_byte(CH_SPACE, 1'b1));
            end
        end

        // After an error every byte must be dropped.
        repeat (24) send_stream_byte(8'($urandom_range(0, 255)));
        i_in_valid <= 1'b0;

        while (stream_results_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fault_count == 0 && stream_results_q.size() == 0) begin
            $display("[y4m_luma_extractor] OK");
        end else begin
            $display("[y4m_luma_extractor] ERROR");
        end
        $finish;
    end

endmodule
